@@ src/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// shared types, scancode constants and character roms for the
// set-1 scancode to ascii translator
// ----------------------------------------------------------------------------
package sct_pkg;

   typedef logic [7:0] code_type;
   typedef logic [6:0] char_type;

   typedef struct packed {
      logic control;
      logic shift;
      logic caps;
   } flags_type;

   localparam code_type CODE_CTRL_MAKE  = 8'h1D;
   localparam code_type CODE_CTRL_BREAK = 8'h9D;
   localparam code_type CODE_SHIFT_MAKE  = 8'h2A;
   localparam code_type CODE_SHIFT_BREAK = 8'hAA;
   localparam code_type CODE_CAPS_MAKE  = 8'h3A;
   localparam code_type CODE_BACKSPACE  = 8'h0E;

   localparam char_type CHAR_NONE      = 7'h00;
   localparam char_type CHAR_BACKSPACE = 7'h08;
   localparam char_type CHAR_LOWER_A   = 7'h61;
   localparam char_type CHAR_LOWER_Z   = 7'h7A;
   localparam char_type CHAR_CTRL_BIAS = 7'h60;

   function automatic char_type plain_char(input logic [6:0] idx);
      char_type c;
      case (idx)
         7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33; 7'h05: c = 7'h34;
         7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37; 7'h09: c = 7'h38;
         7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D; 7'h0D: c = 7'h3D;
         7'h10: c = 7'h71; 7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72;
         7'h14: c = 7'h74; 7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69;
         7'h18: c = 7'h6F; 7'h19: c = 7'h70; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D;
         7'h1C: c = 7'h0A;
         7'h1E: c = 7'h61; 7'h1F: c = 7'h73; 7'h20: c = 7'h64; 7'h21: c = 7'h66;
         7'h22: c = 7'h67; 7'h23: c = 7'h68; 7'h24: c = 7'h6A; 7'h25: c = 7'h6B;
         7'h26: c = 7'h6C; 7'h27: c = 7'h3B; 7'h28: c = 7'h27; 7'h29: c = 7'h60;
         7'h2B: c = 7'h5C;
         7'h2C: c = 7'h7A; 7'h2D: c = 7'h78; 7'h2E: c = 7'h63; 7'h2F: c = 7'h76;
         7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D; 7'h33: c = 7'h2C;
         7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h39: c = 7'h20;
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

   function automatic char_type shifted_char(input logic [6:0] idx);
      char_type c;
      case (idx)
         7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23; 7'h05: c = 7'h24;
         7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26; 7'h09: c = 7'h2A;
         7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F; 7'h0D: c = 7'h2B;
         7'h10: c = 7'h51; 7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52;
         7'h14: c = 7'h54; 7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49;
         7'h18: c = 7'h4F; 7'h19: c = 7'h50; 7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D;
         7'h1C: c = 7'h0A;
         7'h1E: c = 7'h41; 7'h1F: c = 7'h53; 7'h20: c = 7'h44; 7'h21: c = 7'h46;
         7'h22: c = 7'h47; 7'h23: c = 7'h48; 7'h24: c = 7'h4A; 7'h25: c = 7'h4B;
         7'h26: c = 7'h4C; 7'h27: c = 7'h3A; 7'h28: c = 7'h22; 7'h29: c = 7'h7E;
         7'h2B: c = 7'h7C;
         7'h2C: c = 7'h5A; 7'h2D: c = 7'h58; 7'h2E: c = 7'h43; 7'h2F: c = 7'h56;
         7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D; 7'h33: c = 7'h3C;
         7'h34: c = 7'h3E; 7'h35: c = 7'h3F; 7'h39: c = 7'h20;
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

endpackage

@@ src/sct_flags.sv @@
// ----------------------------------------------------------------------------
// sct_flags
// control, shift and caps-lock flags, updated by each processed item
// ----------------------------------------------------------------------------
module sct_flags (
   input  logic               clock,
   input  logic               reset,
   input  logic               update,
   input  sct_pkg::code_type  code,
   output sct_pkg::flags_type flags_next
);
   import sct_pkg::*;

   flags_type flags_ff;

   always_comb begin
      flags_next = flags_ff;
      unique case (code)
         CODE_CTRL_MAKE:   flags_next.control = 1'b1;
         CODE_CTRL_BREAK:  flags_next.control = 1'b0;
         CODE_SHIFT_MAKE:  flags_next.shift   = 1'b1;
         CODE_SHIFT_BREAK: flags_next.shift   = 1'b0;
         CODE_CAPS_MAKE:   flags_next.caps    = ~flags_ff.caps;
         default:          flags_next = flags_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (update) begin
         flags_ff <= flags_next;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (update && code == CODE_CTRL_MAKE) |=> flags_ff.control)
      else $error("control flag not set by control make");

   assert property (@(posedge clock) disable iff (reset)
      (update && code == CODE_CAPS_MAKE) |=> (flags_ff.caps != $past(flags_ff.caps)))
      else $error("caps flag not toggled");

endmodule

@@ src/sct_xlate.sv @@
// ----------------------------------------------------------------------------
// sct_xlate
// maps one scancode and the current flags to an ascii character
// ----------------------------------------------------------------------------
module sct_xlate (
   input  sct_pkg::code_type  code,
   input  sct_pkg::flags_type flags,
   output sct_pkg::char_type  ascii
);
   import sct_pkg::*;

   char_type low;
   char_type high;
   logic     is_letter;

   assign low       = plain_char(code[6:0]);
   assign high      = shifted_char(code[6:0]);
   assign is_letter = (low >= CHAR_LOWER_A) && (low <= CHAR_LOWER_Z);

   always_comb begin
      if (code[7]) begin
         ascii = CHAR_NONE;
      end else if (code == CODE_BACKSPACE) begin
         ascii = CHAR_BACKSPACE;
      end else if (is_letter) begin
         if (flags.control) begin
            ascii = low - CHAR_CTRL_BIAS;
         end else begin
            ascii = (flags.shift ^ flags.caps) ? high : low;
         end
      end else begin
         ascii = flags.shift ? high : low;
      end
   end

endmodule

@@ src/scancode_to_ascii_translator.sv @@
// ----------------------------------------------------------------------------
// scancode_to_ascii_translator
// set-1 scancode bytes in, ascii characters out (0 means no character)
//
//   channel  direction  payload
//   req      in         req_scan_code  [7:0]
//   rsp      out        rsp_ascii_char [6:0]
//
// one item per cycle sustained while rsp_stall is low; input register to
// result register, with the rom lookup and flag update between them
// reset clears both valid bits and the modifier flags
// a stalled result holds the result register; the input register then
// holds and stalls req, so at most two items are in flight
// ----------------------------------------------------------------------------
module scancode_to_ascii_translator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sct_pkg::code_type req_scan_code,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sct_pkg::char_type rsp_ascii_char
);
   import sct_pkg::*;

   logic      in_valid_ff;
   code_type  in_code_ff;
   logic      out_valid_ff;
   char_type  out_char_ff;
   logic      advance;
   logic      in_load;
   flags_type flags_next;
   char_type  out_char_in;

   assign advance   = ~out_valid_ff | ~rsp_stall;
   assign in_load   = ~in_valid_ff | advance;
   assign req_stall = ~in_load;

   sct_flags u_flags (
      .clock      (clock),
      .reset      (reset),
      .update     (in_valid_ff & advance),
      .code       (in_code_ff),
      .flags_next (flags_next)
   );

   sct_xlate u_xlate (
      .code  (in_code_ff),
      .flags (flags_next),
      .ascii (out_char_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_code_ff <= req_scan_code;
      end
      if (advance && in_valid_ff) begin
         out_char_ff <= out_char_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_ascii_char = out_char_ff;

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && in_code_ff[7]) |=> (rsp_valid && rsp_ascii_char == CHAR_NONE))
      else $error("break code gave a character");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && in_code_ff == CODE_BACKSPACE)
      |=> (rsp_valid && rsp_ascii_char == CHAR_BACKSPACE))
      else $error("backspace not translated");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// set-1 scancode translator check with random handshakes on both channels
//
// a directed opening covers the byte extremes, backspace, break codes,
// modifier make and break codes, control, shift and caps on letters and
// other keys, and unmapped codes. Random key events follow. Each scancode
// is run through an independent model of the three modifier flags and the
// character maps, and every result is checked in order against it.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sct_pkg::*;

   localparam int NUM_RANDOM_CODES = 800;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int IDLE_LIMIT       = 500;

   class translation_scoreboard;
      char_type plain_map[128];
      char_type shift_map[128];
      bit       control_down;
      bit       shift_down;
      bit       caps_on;
      char_type expected_chars[$];
      int       mismatches;
      int       checked;
      int       control_letters;
      int       upper_letters;

      function new();
         foreach (plain_map[i]) begin
            plain_map[i] = CHAR_NONE;
            shift_map[i] = CHAR_NONE;
         end
         add_keys('h02, "1234567890-=", "!@#$%^&*()_+");
         add_keys('h10, "qwertyuiop[]", "QWERTYUIOP{}");
         add_keys('h1C, "\n", "\n");
         add_keys('h1E, "asdfghjkl;'", "ASDFGHJKL:\"");
         add_keys('h2B, "\\", "|");
         add_keys('h2C, "zxcvbnm,./", "ZXCVBNM<>?");
         add_keys('h39, " ", " ");
         // grave accent and tilde
         plain_map[8'h29] = 7'h60;
         shift_map[8'h29] = 7'h7E;
      endfunction

      function void add_keys(int first, string lower_row, string upper_row);
         for (int i = 0; i < lower_row.len(); i++) begin
            plain_map[first + i] = char_type'(lower_row[i]);
            shift_map[first + i] = char_type'(upper_row[i]);
         end
      endfunction

      function void note_code(code_type code);
         char_type low;
         char_type ch;
         if (code == CODE_CTRL_MAKE) control_down = 1'b1;
         else if (code == CODE_CTRL_BREAK) control_down = 1'b0;
         if (code == CODE_CAPS_MAKE) caps_on = !caps_on;
         if (code == CODE_SHIFT_MAKE) shift_down = 1'b1;
         else if (code == CODE_SHIFT_BREAK) shift_down = 1'b0;
         low = plain_map[code[6:0]];
         if (code[7]) begin
            ch = CHAR_NONE;
         end else if (code == CODE_BACKSPACE) begin
            ch = CHAR_BACKSPACE;
         end else if (low >= CHAR_LOWER_A && low <= CHAR_LOWER_Z) begin
            if (control_down) begin
               ch = low - CHAR_LOWER_A + 7'd1;
               control_letters++;
            end else if (shift_down ^ caps_on) begin
               ch = shift_map[code[6:0]];
               upper_letters++;
            end else begin
               ch = low;
            end
         end else begin
            ch = shift_down ? shift_map[code[6:0]] : low;
         end
         expected_chars.push_back(ch);
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      task check_char(char_type got);
         char_type want;
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected item, char 0x%02h", got));
         end else begin
            want = expected_chars.pop_front();
            checked++;
            if (got !== want)
               report_mismatch($sformatf("item %0d: char 0x%02h, expected 0x%02h",
                                         checked, got, want));
         end
      endtask
   endclass

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   code_type req_scan_code = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   char_type rsp_ascii_char;

   translation_scoreboard sb = new();
   int codes_sent = 0;
   int idle_cycles = 0;

   scancode_to_ascii_translator u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_scan_code  (req_scan_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   task send_code(code_type code, bit back_to_back);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_scan_code <= code;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      sb.note_code(code);
      codes_sent++;
      @(posedge clock);
   endtask

   function automatic code_type random_code();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)  return $urandom_range(0, 1) ? CODE_CTRL_MAKE : CODE_CTRL_BREAK;
      if (pick < 16) return $urandom_range(0, 1) ? CODE_SHIFT_MAKE : CODE_SHIFT_BREAK;
      if (pick < 20) return $urandom_range(0, 3) != 0 ? CODE_CAPS_MAKE : 8'hBA;
      if (pick < 70) return code_type'($urandom_range(8'h02, 8'h39));
      if (pick < 85) return code_type'(8'h80 | $urandom_range(8'h02, 8'h39));
      return code_type'($urandom_range(0, 255));
   endfunction

   // result side: random stalls, stall-free stretches and two long hold-offs
   initial begin
      int       n_results;
      int       hold;
      char_type got;
      n_results = 0;
      wait (reset == 1'b0);
      forever begin
         hold = $urandom_range(0, 6);
         if ((n_results % 100) >= 75) hold = 0;
         if (n_results == 150 || n_results == 500) hold = LONG_HOLD_CYCLES;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         got = rsp_ascii_char;
         @(posedge clock);
         sb.check_char(got);
         n_results++;
      end
   end

   initial begin
      code_type directed_codes[$];
      directed_codes = '{8'h00, 8'hFF, 8'h7F, 8'h80, CODE_BACKSPACE,
                         8'h1E, CODE_CTRL_MAKE, 8'h2C, 8'h02, CODE_SHIFT_MAKE,
                         8'h1E, CODE_CTRL_BREAK, 8'h10, 8'h02, CODE_CAPS_MAKE,
                         8'h10, CODE_SHIFT_BREAK, 8'h10, 8'h0C, 8'hBA,
                         8'h35, CODE_CAPS_MAKE, 8'h1C, 8'h39, 8'h36};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_codes[i]) send_code(directed_codes[i], i >= 20);
      for (int i = 0; i < NUM_RANDOM_CODES; i++)
         send_code(random_code(), (i % 100) < 20);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("covered %0d scancodes and checked %0d characters", codes_sent, sb.checked);
      $display("letters under control: %0d, upper-case letters: %0d, mismatches: %0d",
               sb.control_letters, sb.upper_letters, sb.mismatches);
      if (sb.mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ files.f @@
src/sct_pkg.sv
src/sct_flags.sv
src/sct_xlate.sv
src/scancode_to_ascii_translator.sv
bench/testbench.sv
